// ----- sv/chs_pkg.sv -----
package chs_pkg;

  localparam int BUCKETS     = 256;
  localparam int WAYS        = 8;
  localparam int VALUE_BITS  = 32;
  localparam int CFG_BITS    = 9;
  localparam int IN_VALUE_BITS = 32;
  localparam int BUCKET_BITS = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int REM_BITS    = $clog2(BUCKETS + 1);
  localparam int WAY_BITS    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FILL_BITS   = $clog2(WAYS + 1);
  localparam int ENTRY_DEPTH = BUCKETS * WAYS;
  localparam int ENTRY_BITS  = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int CNT_BITS    = $clog2(VALUE_BITS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = 1;
  localparam int QCNT_BITS   = 2;
  localparam logic [CFG_BITS-1:0] BUCKET_COUNT_RESET = CFG_BITS'(256);

  localparam logic KIND_CHECK  = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [IN_VALUE_BITS-1:0] value;
  } in_t;

  typedef struct packed {
    logic found;
    logic status;
  } out_t;

  typedef struct packed {
    logic                   kind;
    logic [VALUE_BITS-1:0]  value;
    logic [BUCKET_BITS-1:0] bucket;
  } item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FILL,
    B_WALK
  } back_state_t;

endpackage

// ----- sv/chs_front.sv -----
module chs_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_ready,
  input  chs_pkg::in_t                   item,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [chs_pkg::CFG_BITS-1:0]   cfg_data,
  output logic                           push_valid,
  input  logic                           push_ready,
  output chs_pkg::item_t                 push_data
);
  import chs_pkg::*;

  front_state_t          state, state_next;
  logic [CFG_BITS-1:0]   bucket_count;
  logic [REM_BITS-1:0]   divisor;
  logic [REM_BITS-1:0]   divisor_next;
  logic [REM_BITS-1:0]   rem;
  logic [REM_BITS:0]     trial;
  logic [VALUE_BITS-1:0] val_sh;
  logic [VALUE_BITS-1:0] value;
  logic                  kind;
  logic [CNT_BITS-1:0]   cnt;

  always_comb begin
    if (bucket_count == '0) begin
      divisor_next = REM_BITS'(1);
    end else if (32'(bucket_count) > BUCKETS) begin
      divisor_next = REM_BITS'(BUCKETS);
    end else begin
      divisor_next = REM_BITS'(bucket_count);
    end
  end

  assign trial = {rem, val_sh[VALUE_BITS-1]};

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (item_valid) state_next = F_DIV;
      F_DIV:  if (cnt == '0) state_next = F_PUSH;
      F_PUSH: if (push_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    item_ready = (state == F_IDLE);
    push_valid = (state == F_PUSH);
    cfg_ready  = 1'b1;
    push_data.kind   = kind;
    push_data.value  = value;
    push_data.bucket = BUCKET_BITS'(rem);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= F_IDLE;
      bucket_count <= BUCKET_COUNT_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        bucket_count <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (item_valid) begin
          kind    <= item.kind;
          value   <= VALUE_BITS'(item.value);
          val_sh  <= VALUE_BITS'(item.value);
          rem     <= '0;
          cnt     <= CNT_BITS'(VALUE_BITS - 1);
          divisor <= divisor_next;
        end
      end
      F_DIV: begin
        if (trial >= {1'b0, divisor}) begin
          rem <= REM_BITS'(trial - {1'b0, divisor});
        end else begin
          rem <= REM_BITS'(trial);
        end
        val_sh <= {val_sh[VALUE_BITS-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/chs_fifo.sv -----
module chs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  chs_pkg::item_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output chs_pkg::item_t pop_data
);
  import chs_pkg::*;

  item_t                slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (32'(count) < QUEUE_DEPTH);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- sv/chs_back.sv -----
module chs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  chs_pkg::item_t q_data,
  output logic           result_valid,
  input  logic           result_ready,
  output chs_pkg::out_t  result
);
  import chs_pkg::*;

  logic [FILL_BITS-1:0]  fill_mem [BUCKETS];
  logic [VALUE_BITS-1:0] entry_mem [ENTRY_DEPTH];
  logic [BUCKETS-1:0]    fill_vld;

  back_state_t           state, state_next;
  item_t                 cur;
  logic [WAY_BITS-1:0]   idx;
  logic [FILL_BITS-1:0]  fill_n;
  logic [FILL_BITS-1:0]  fill_rdata;
  logic                  fill_vld_q;
  logic [VALUE_BITS-1:0] ent_rdata;

  logic [FILL_BITS-1:0]  fill_raw;
  logic [FILL_BITS-1:0]  fill_cur;
  logic [ENTRY_BITS-1:0] base;
  logic [ENTRY_BITS-1:0] ent_raddr;
  logic [ENTRY_BITS-1:0] ent_waddr;
  logic                  ent_we;
  logic                  fill_we;
  logic [FILL_BITS-1:0]  fill_wdata;
  logic                  done;
  logic                  done_found;
  logic                  done_status;
  logic                  hit;
  logic                  last;

  assign fill_raw = fill_vld_q ? fill_rdata : '0;
  assign fill_cur = (32'(fill_raw) > WAYS) ? FILL_BITS'(WAYS) : fill_raw;
  assign base     = ENTRY_BITS'(cur.bucket) * ENTRY_BITS'(WAYS);
  assign hit      = (ent_rdata == cur.value);
  assign last     = ((FILL_BITS'(idx) + 1'b1) == fill_n);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (q_valid && !result_valid) state_next = B_FILL;
      B_FILL: begin
        if (cur.kind == KIND_CHECK && fill_cur != '0) state_next = B_WALK;
        else state_next = B_IDLE;
      end
      B_WALK: if (hit || last) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_ready     = 1'b0;
    done        = 1'b0;
    done_found  = 1'b0;
    done_status = 1'b0;
    fill_we     = 1'b0;
    fill_wdata  = fill_cur + 1'b1;
    ent_we      = 1'b0;
    ent_waddr   = base + ENTRY_BITS'(fill_cur);
    ent_raddr   = base;
    unique case (state)
      B_IDLE: q_ready = !result_valid;
      B_FILL: begin
        if (cur.kind == KIND_INSERT) begin
          done = 1'b1;
          if (fill_cur == '0) begin
            fill_we = (cur.value != '0);
            ent_we  = (cur.value != '0);
          end else if (32'(fill_cur) >= WAYS) begin
            done_status = 1'b1;
          end else begin
            fill_we = 1'b1;
            ent_we  = 1'b1;
          end
        end else begin
          done = (fill_cur == '0);
        end
      end
      B_WALK: begin
        ent_raddr  = base + ENTRY_BITS'(idx) + 1'b1;
        done       = hit || last;
        done_found = hit;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
      fill_vld     <= '0;
    end else begin
      state <= state_next;
      if (done) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (fill_we) begin
        fill_vld[cur.bucket] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur <= q_data;
    end
    if (state == B_FILL) begin
      idx    <= '0;
      fill_n <= fill_cur;
    end else if (state == B_WALK) begin
      idx <= idx + 1'b1;
    end
    if (done) begin
      result.found  <= done_found;
      result.status <= done_status;
    end
    fill_vld_q <= fill_vld[q_data.bucket];
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[cur.bucket] <= fill_wdata;
    end
    fill_rdata <= fill_mem[q_data.bucket];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      entry_mem[ent_waddr] <= cur.value;
    end
    ent_rdata <= entry_mem[ent_raddr];
  end

endmodule

// ----- sv/chained_hash_set_core.sv -----
// The front accepts an item, runs a bit-serial modulo over all 32 value bits, then
// pushes; the back settles an insert in its fill state and a check after up to 8 entry reads.
// The remainder divider makes one bit per cycle, and the front takes no new item until
// it has pushed the last one. The back sits behind a two-entry queue.
// Reset clears control state and the 256 bucket fill valid bits; there is no
// clearing pass, and entries beyond a bucket's fill count are never compared.
module chained_hash_set_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  chs_pkg::in_t                 item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output chs_pkg::out_t                result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [chs_pkg::CFG_BITS-1:0] cfg_data
);
  import chs_pkg::*;

  logic  push_valid;
  logic  push_ready;
  item_t push_data;
  logic  q_valid;
  logic  q_ready;
  item_t q_data;

  chs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  chs_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  chs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_data       (q_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("front accepted a beat while still dividing");

  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    q_valid && q_ready |-> !result_valid)
    else $error("back took an item while a result was pending");

  a_result_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.found && result.status))
    else $error("result flags both found and dropped");

endmodule
